FILE: rtl/mau_pkg.sv
// Shared constants, codes and types of the modular arithmetic unit.
package mau_pkg;

	// Modulus register width and the widths that follow from it
	localparam int MOD_WIDTH  = 31;
	localparam int OPND_WIDTH = 32;
	localparam int EXP_WIDTH  = 31;
	localparam int RES_WIDTH  = 31;
	localparam int CNT_WIDTH  = $clog2(OPND_WIDTH + 1);

	localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(64'd1000000007);

	// Operation codes of the action field
	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_NEG = 3'd4;
	localparam logic [2:0] ACT_POW = 3'd5;

	// Datapath commands issued by the controller
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_RED_A,
		CMD_RED_B,
		CMD_STEP,
		CMD_WB_A,
		CMD_WB_B,
		CMD_POW_INIT,
		CMD_MUL_ACC,
		CMD_MUL_SQ,
		CMD_MUL_FIN,
		CMD_WB_ACC,
		CMD_WB_BASE,
		CMD_FINISH
	} cmd_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_A_GO,
		ST_RED_A,
		ST_RED_B_GO,
		ST_RED_B,
		ST_DISPATCH,
		ST_POW_INIT,
		ST_POW_CHECK,
		ST_MUL_ACC,
		ST_SQ_GO,
		ST_MUL_SQ,
		ST_FIN_GO,
		ST_MUL_FIN,
		ST_FINISH
	} state_t;

	// Status reported by the datapath
	typedef struct packed {
		logic       eng_done;
		logic       exp_zero;
		logic       exp_lsb;
		logic       b_zero;
		logic       b_nonpos;
		logic [2:0] action;
	} dp_status_t;

endpackage

FILE: rtl/mau_datapath.sv
// Datapath: operand registers, bit-serial modular engine and result register.
module mau_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mau_pkg::MOD_WIDTH-1:0] cfg_wr_data,
	input  logic [2:0]                   action,
	input  logic signed [mau_pkg::OPND_WIDTH-1:0] operand_a,
	input  logic signed [mau_pkg::OPND_WIDTH-1:0] operand_b,
	input  mau_pkg::cmd_t                cmd,
	output mau_pkg::dp_status_t          status,
	output logic [mau_pkg::MOD_WIDTH-1:0] res_word
);
	import mau_pkg::*;

	localparam int W = MOD_WIDTH;

	logic [W-1:0]          mod_q;
	logic [CNT_WIDTH-1:0]  cnt_q;
	logic                  mul_mode_q;
	logic [2:0]            op_q;
	logic [OPND_WIDTH-1:0] raw_a_q;
	logic [OPND_WIDTH-1:0] raw_b_q;
	logic [W-1:0]          ra_q;
	logic [W-1:0]          rb_q;
	logic [W-1:0]          acc_q;
	logic [W-1:0]          base_q;
	logic [EXP_WIDTH-1:0]  exp_q;
	logic [W-1:0]          eng_r_q;
	logic [W-1:0]          eng_x_q;
	logic [OPND_WIDTH-1:0] sh_q;
	logic [W-1:0]          res_q;

	logic [W-1:0]          m_eff;
	logic [OPND_WIDTH-1:0] mag_a;
	logic [OPND_WIDTH-1:0] mag_b;
	logic [W-1:0]          addend;
	logic [W+1:0]          t_sum;
	logic [W+1:0]          m1;
	logic [W+1:0]          m2;
	logic [W+1:0]          t_red;
	logic                  fix_sign;
	logic [W-1:0]          fix_val;
	logic [W:0]            add_sum;
	logic [W-1:0]          add_res;
	logic [W-1:0]          sub_diff;
	logic [W-1:0]          sub_res;
	logic [W-1:0]          neg_res;
	logic [W-1:0]          fin_val;
	logic [W-1:0]          fin_y;

	// Effective modulus: 0 and 1 act as 2
	assign m_eff = (mod_q[W-1:1] == '0) ? W'(2) : mod_q;

	// Magnitudes of the raw operands
	assign mag_a = raw_a_q[OPND_WIDTH-1] ? (OPND_WIDTH'(0) - raw_a_q) : raw_a_q;
	assign mag_b = raw_b_q[OPND_WIDTH-1] ? (OPND_WIDTH'(0) - raw_b_q) : raw_b_q;

	// Engine step: r = (2r + addend) mod m, with 2r + addend below 3m
	assign addend = mul_mode_q ? (sh_q[OPND_WIDTH-1] ? eng_x_q : '0)
	                           : W'(sh_q[OPND_WIDTH-1]);
	assign t_sum  = {1'b0, eng_r_q, 1'b0} + {2'b00, addend};
	assign m1     = {2'b00, m_eff};
	assign m2     = {1'b0, m_eff, 1'b0};

	always_comb begin
		if (t_sum >= m2) begin
			t_red = t_sum - m2;
		end else if (t_sum >= m1) begin
			t_red = t_sum - m1;
		end else begin
			t_red = t_sum;
		end
	end

	// Residue of a negative operand is m - r unless r is zero
	assign fix_sign = (cmd == CMD_WB_A) ? raw_a_q[OPND_WIDTH-1] : raw_b_q[OPND_WIDTH-1];
	assign fix_val  = (fix_sign && (eng_r_q != '0)) ? (m_eff - eng_r_q) : eng_r_q;

	// Combinational add, subtract and negate
	assign add_sum  = {1'b0, ra_q} + {1'b0, rb_q};
	assign add_res  = (add_sum >= {1'b0, m_eff}) ? W'(add_sum - {1'b0, m_eff}) : W'(add_sum);
	assign sub_diff = ra_q - rb_q;
	assign sub_res  = (ra_q >= rb_q) ? sub_diff : (sub_diff + m_eff);
	assign neg_res  = (ra_q == '0) ? '0 : (m_eff - ra_q);

	// Result select
	always_comb begin
		case (op_q)
			ACT_ADD: fin_val = add_res;
			ACT_SUB: fin_val = sub_res;
			ACT_MUL: fin_val = acc_q;
			ACT_DIV: fin_val = (rb_q == '0) ? '0 : acc_q;
			ACT_NEG: fin_val = neg_res;
			ACT_POW: fin_val = acc_q;
			default: fin_val = '0;
		endcase
	end

	// Second factor of the final multiply
	assign fin_y = (op_q == ACT_MUL) ? rb_q : acc_q;

	// Control registers: modulus, step counter, engine mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q      <= MOD_RESET;
			cnt_q      <= '0;
			mul_mode_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mod_q <= cfg_wr_data;
			end
			case (cmd)
				CMD_RED_A, CMD_RED_B: begin
					cnt_q      <= CNT_WIDTH'(OPND_WIDTH);
					mul_mode_q <= 1'b0;
				end
				CMD_MUL_ACC, CMD_MUL_SQ, CMD_MUL_FIN: begin
					cnt_q      <= CNT_WIDTH'(W);
					mul_mode_q <= 1'b1;
				end
				CMD_STEP: cnt_q <= cnt_q - CNT_WIDTH'(1);
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q    <= action;
				raw_a_q <= operand_a;
				raw_b_q <= operand_b;
				acc_q   <= W'(1);
			end
			CMD_RED_A: begin
				sh_q    <= mag_a;
				eng_r_q <= '0;
			end
			CMD_RED_B: begin
				sh_q    <= mag_b;
				eng_r_q <= '0;
			end
			CMD_STEP: begin
				eng_r_q <= t_red[W-1:0];
				sh_q    <= sh_q << 1;
			end
			CMD_WB_A: ra_q <= fix_val;
			CMD_WB_B: rb_q <= fix_val;
			CMD_POW_INIT: begin
				if (op_q == ACT_DIV) begin
					base_q <= rb_q;
					exp_q  <= EXP_WIDTH'(m_eff - W'(2));
				end else begin
					base_q <= ra_q;
					exp_q  <= raw_b_q[EXP_WIDTH-1:0];
				end
			end
			CMD_MUL_ACC: begin
				eng_x_q <= base_q;
				sh_q    <= OPND_WIDTH'(acc_q) << (OPND_WIDTH - W);
				eng_r_q <= '0;
			end
			CMD_MUL_SQ: begin
				eng_x_q <= base_q;
				sh_q    <= OPND_WIDTH'(base_q) << (OPND_WIDTH - W);
				eng_r_q <= '0;
			end
			CMD_MUL_FIN: begin
				eng_x_q <= ra_q;
				sh_q    <= OPND_WIDTH'(fin_y) << (OPND_WIDTH - W);
				eng_r_q <= '0;
			end
			CMD_WB_ACC: acc_q <= eng_r_q;
			CMD_WB_BASE: begin
				base_q <= eng_r_q;
				exp_q  <= exp_q >> 1;
			end
			CMD_FINISH: res_q <= fin_val;
			default: ;
		endcase
	end

	assign status.eng_done = (cnt_q == '0);
	assign status.exp_zero = (exp_q == '0);
	assign status.exp_lsb  = exp_q[0];
	assign status.b_zero   = (rb_q == '0);
	assign status.b_nonpos = raw_b_q[OPND_WIDTH-1] || (raw_b_q == '0);
	assign status.action   = op_q;

	assign res_word = res_q;

	// Engine residue stays reduced after every step
	a_step_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_STEP) |=> (eng_r_q < m_eff))
		else $error("engine residue not below modulus");

	// Operand a residue is reduced when written back
	a_wb_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_WB_A) |=> (ra_q < m_eff))
		else $error("operand a residue not below modulus");

	// Delivered word is a residue
	a_res_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_FINISH) |=> (res_q < m_eff))
		else $error("result not below modulus");

endmodule

FILE: rtl/mau_ctrl.sv
// Controller: sequences reductions, square-and-multiply and result delivery.
module mau_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mau_pkg::dp_status_t status,
	output mau_pkg::cmd_t       cmd
);
	import mau_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = CMD_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = ST_RED_A_GO;
				end
			end
			ST_RED_A_GO: begin
				cmd     = CMD_RED_A;
				state_d = ST_RED_A;
			end
			ST_RED_A: begin
				if (status.eng_done) begin
					cmd     = CMD_WB_A;
					state_d = ST_RED_B_GO;
				end else begin
					cmd = CMD_STEP;
				end
			end
			ST_RED_B_GO: begin
				cmd     = CMD_RED_B;
				state_d = ST_RED_B;
			end
			ST_RED_B: begin
				if (status.eng_done) begin
					cmd     = CMD_WB_B;
					state_d = ST_DISPATCH;
				end else begin
					cmd = CMD_STEP;
				end
			end
			ST_DISPATCH: begin
				case (status.action)
					ACT_MUL: state_d = ST_FIN_GO;
					ACT_DIV: state_d = status.b_zero ? ST_FINISH : ST_POW_INIT;
					ACT_POW: state_d = status.b_nonpos ? ST_FINISH : ST_POW_INIT;
					default: state_d = ST_FINISH;
				endcase
			end
			ST_POW_INIT: begin
				cmd     = CMD_POW_INIT;
				state_d = ST_POW_CHECK;
			end
			ST_POW_CHECK: begin
				if (status.exp_zero) begin
					state_d = (status.action == ACT_DIV) ? ST_FIN_GO : ST_FINISH;
				end else if (status.exp_lsb) begin
					cmd     = CMD_MUL_ACC;
					state_d = ST_MUL_ACC;
				end else begin
					cmd     = CMD_MUL_SQ;
					state_d = ST_MUL_SQ;
				end
			end
			ST_MUL_ACC: begin
				if (status.eng_done) begin
					cmd     = CMD_WB_ACC;
					state_d = ST_SQ_GO;
				end else begin
					cmd = CMD_STEP;
				end
			end
			ST_SQ_GO: begin
				cmd     = CMD_MUL_SQ;
				state_d = ST_MUL_SQ;
			end
			ST_MUL_SQ: begin
				if (status.eng_done) begin
					cmd     = CMD_WB_BASE;
					state_d = ST_POW_CHECK;
				end else begin
					cmd = CMD_STEP;
				end
			end
			ST_FIN_GO: begin
				cmd     = CMD_MUL_FIN;
				state_d = ST_MUL_FIN;
			end
			ST_MUL_FIN: begin
				if (status.eng_done) begin
					cmd     = CMD_WB_ACC;
					state_d = ST_FINISH;
				end else begin
					cmd = CMD_STEP;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd     = CMD_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == CMD_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// An accepted word starts work and blocks the input
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input still open after accepting a word");

	// A new output word only comes from the finish step
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_FINISH))
		else $error("output valid raised outside finish");

	// A waiting output word is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output valid dropped before the word was taken");

endmodule

FILE: rtl/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit: controller plus datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  input    | in_valid / in_ready    | action, operand_a, operand_b
//  output   | out_valid / out_ready  | result
//  config   | cfg_wr_en              | cfg_wr_data (modulus)
//
// One word at a time through a bit-serial engine, one engine step per cycle.
// Operands a and b are reduced in turn; add, subtract and negate then finish,
// multiply runs one engine multiply, power runs square-and-multiply over
// operand_b, and divide raises b to m - 2 and then multiplies by a.
// Reset leaves the modulus at 1000000007 and the unit idle with no result.
// A finished word waits in the output register while the next word is taken.
module modular_arithmetic_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mau_pkg::MOD_WIDTH-1:0]  cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    action,
	input  logic signed [mau_pkg::OPND_WIDTH-1:0] operand_a,
	input  logic signed [mau_pkg::OPND_WIDTH-1:0] operand_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mau_pkg::RES_WIDTH-1:0]  result
);
	import mau_pkg::*;

	cmd_t                 cmd;
	dp_status_t           status;
	logic [MOD_WIDTH-1:0] res_word;

	mau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mau_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.action      (action),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.cmd         (cmd),
		.status      (status),
		.res_word    (res_word)
	);

	assign result = RES_WIDTH'(res_word);

endmodule
